@@ hdl/ps2dec_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2dec_pkg
// Shared types, byte codes and the US layout character table for the
// PS/2 set 2 scan code decoder.
// ----------------------------------------------------------------------------
package ps2dec_pkg;

	localparam logic [7:0] BYTE_BREAK  = 8'hF0;
	localparam logic [7:0] BYTE_EXT    = 8'hE0;
	localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
	localparam logic [7:0] BYTE_NULL   = 8'h00;
	localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
	localparam logic [7:0] BYTE_ECHO   = 8'hEE;
	localparam logic [7:0] BYTE_ACK    = 8'hFA;
	localparam logic [7:0] BYTE_RSP_LO = 8'hFC;

	typedef struct packed {
		logic [7:0] key_code;
		logic       extended;
		logic       pressed;
		logic [6:0] ascii_char;
	} ps2dec_evt_t;

	// returns {shifted, unshifted} character, zero where the key has none
	function automatic logic [13:0] char_pair(input logic [6:0] code);
		logic [13:0] pair;
		pair = 14'h0;
		unique case (code)
			7'h0D: pair = {7'h09, 7'h09};
			7'h0E: pair = {7'h7E, 7'h60};
			7'h15: pair = {7'h51, 7'h71};
			7'h16: pair = {7'h21, 7'h31};
			7'h1A: pair = {7'h5A, 7'h7A};
			7'h1B: pair = {7'h53, 7'h73};
			7'h1C: pair = {7'h41, 7'h61};
			7'h1D: pair = {7'h57, 7'h77};
			7'h1E: pair = {7'h40, 7'h32};
			7'h21: pair = {7'h43, 7'h63};
			7'h22: pair = {7'h58, 7'h78};
			7'h23: pair = {7'h44, 7'h64};
			7'h24: pair = {7'h45, 7'h65};
			7'h25: pair = {7'h24, 7'h34};
			7'h26: pair = {7'h23, 7'h33};
			7'h29: pair = {7'h20, 7'h20};
			7'h2A: pair = {7'h56, 7'h76};
			7'h2B: pair = {7'h46, 7'h66};
			7'h2C: pair = {7'h54, 7'h74};
			7'h2D: pair = {7'h52, 7'h72};
			7'h2E: pair = {7'h25, 7'h35};
			7'h31: pair = {7'h4E, 7'h6E};
			7'h32: pair = {7'h42, 7'h62};
			7'h33: pair = {7'h48, 7'h68};
			7'h34: pair = {7'h47, 7'h67};
			7'h35: pair = {7'h59, 7'h79};
			7'h36: pair = {7'h5E, 7'h36};
			7'h3A: pair = {7'h4D, 7'h6D};
			7'h3B: pair = {7'h4A, 7'h6A};
			7'h3C: pair = {7'h55, 7'h75};
			7'h3D: pair = {7'h26, 7'h37};
			7'h3E: pair = {7'h2A, 7'h38};
			7'h41: pair = {7'h3C, 7'h2C};
			7'h42: pair = {7'h4B, 7'h6B};
			7'h43: pair = {7'h49, 7'h69};
			7'h44: pair = {7'h4F, 7'h6F};
			7'h45: pair = {7'h29, 7'h30};
			7'h46: pair = {7'h28, 7'h39};
			7'h49: pair = {7'h3E, 7'h2E};
			7'h4A: pair = {7'h3F, 7'h2F};
			7'h4B: pair = {7'h4C, 7'h6C};
			7'h4C: pair = {7'h3A, 7'h3B};
			7'h4D: pair = {7'h50, 7'h70};
			7'h4E: pair = {7'h5F, 7'h2D};
			7'h52: pair = {7'h22, 7'h27};
			7'h54: pair = {7'h7B, 7'h5B};
			7'h55: pair = {7'h2B, 7'h3D};
			7'h5A: pair = {7'h0A, 7'h0A};
			7'h5B: pair = {7'h7D, 7'h5D};
			7'h5D: pair = {7'h7C, 7'h5C};
			7'h66: pair = {7'h08, 7'h08};
			default: pair = 14'h0;
		endcase
		return pair;
	endfunction

endpackage

@@ hdl/ps2dec_fsm.sv @@
// ----------------------------------------------------------------------------
// ps2dec_fsm
// Prefix tracking state machine and key event decode for one scan byte.
// ----------------------------------------------------------------------------
module ps2dec_fsm
	import ps2dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  scan_byte,
	input  logic        shifted,
	output logic        evt_valid,
	output ps2dec_evt_t evt
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_BRK   = 11'b000_0000_0010,
		ST_EXT   = 11'b000_0000_0100,
		ST_XBRK  = 11'b000_0000_1000,
		ST_SKIP7 = 11'b000_0001_0000,
		ST_SKIP6 = 11'b000_0010_0000,
		ST_SKIP5 = 11'b000_0100_0000,
		ST_SKIP4 = 11'b000_1000_0000,
		ST_SKIP3 = 11'b001_0000_0000,
		ST_SKIP2 = 11'b010_0000_0000,
		ST_SKIP1 = 11'b100_0000_0000
	} ps2dec_state_t;

	ps2dec_state_t state_q;
	ps2dec_state_t state_nxt;
	logic          filler;
	logic          skipping;
	logic [13:0]   pair;

	assign filler = (scan_byte == BYTE_NULL) || (scan_byte == BYTE_BAT_OK) ||
		(scan_byte == BYTE_ECHO) || (scan_byte == BYTE_ACK) || (scan_byte >= BYTE_RSP_LO);
	assign pair   = char_pair(scan_byte[6:0]);

	always_comb begin
		state_nxt      = state_q;
		evt_valid      = 1'b0;
		skipping       = 1'b0;
		evt.key_code   = scan_byte;
		evt.extended   = 1'b0;
		evt.pressed    = 1'b1;
		evt.ascii_char = scan_byte[7] ? 7'h0 : (shifted ? pair[13:7] : pair[6:0]);
		unique case (state_q)
			ST_SKIP7: begin skipping = 1'b1; state_nxt = ST_SKIP6; end
			ST_SKIP6: begin skipping = 1'b1; state_nxt = ST_SKIP5; end
			ST_SKIP5: begin skipping = 1'b1; state_nxt = ST_SKIP4; end
			ST_SKIP4: begin skipping = 1'b1; state_nxt = ST_SKIP3; end
			ST_SKIP3: begin skipping = 1'b1; state_nxt = ST_SKIP2; end
			ST_SKIP2: begin skipping = 1'b1; state_nxt = ST_SKIP1; end
			ST_SKIP1: begin skipping = 1'b1; state_nxt = ST_IDLE; end
			ST_BRK: begin
				if (!filler) begin
					evt_valid   = 1'b1;
					evt.pressed = 1'b0;
					state_nxt   = ST_IDLE;
				end
			end
			ST_EXT: begin
				if (!filler) begin
					if (scan_byte == BYTE_BREAK) begin
						state_nxt = ST_XBRK;
					end else begin
						evt_valid    = 1'b1;
						evt.extended = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end
			end
			ST_XBRK: begin
				if (!filler) begin
					evt_valid    = 1'b1;
					evt.extended = 1'b1;
					evt.pressed  = 1'b0;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				if (!filler) begin
					if (scan_byte == BYTE_BREAK) begin
						state_nxt = ST_BRK;
					end else if (scan_byte == BYTE_EXT) begin
						state_nxt = ST_EXT;
					end else if (scan_byte == BYTE_PAUSE) begin
						state_nxt = ST_SKIP7;
					end else begin
						evt_valid = 1'b1;
						state_nxt = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTH
	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		skipping |-> !evt_valid)
		else $error("event produced during pause skip");
	a_evt_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && evt_valid |=> state_q == ST_IDLE)
		else $error("state not idle after key event");
	a_skip_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == ST_SKIP1 |=> state_q == ST_IDLE)
		else $error("pause skip did not end in idle");
	a_high_nochar: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.key_code[7] |-> evt.ascii_char == 7'h0)
		else $error("character given for code above 127");
`endif

endmodule

@@ hdl/ps2_set2_scancode_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder_core
// PS/2 scan code set 2 byte stream to key event decoder.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one received keyboard byte per word on s_tdata, with
//   the shift flag on s_tuser. Master side gives one key event per key byte:
//   code and character on m_tdata, extended and pressed flags on m_tuser.
//   Prefix bytes (F0, E0, E1 plus the seven pause bytes after E1) and
//   filler/response bytes give no word on the master side.
//   A byte is held in the input register, decoded there, and its event is
//   registered in the output register as the byte leaves the input
//   register; m_tvalid is driven from that output register. One byte is
//   taken every cycle while the output register is free or being taken;
//   the state register updates as each byte leaves the input register.
//   When m_tready is low with an event held, one more byte may enter the
//   input register, then s_tready drops until the event is taken.
//   Reset clears both valid flags and returns the decoder to idle.
// ----------------------------------------------------------------------------
module ps2_set2_scancode_decoder_core
	import ps2dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	input  logic        s_tuser,   // [0] shifted
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] key_code, [14:8] ascii_char, [15] zero
	output logic [1:0]  m_tuser    // [0] extended, [1] pressed
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        shift_s1;
	logic        valid_s2;
	ps2dec_evt_t evt_s2;
	logic        adv2;
	logic        step;
	logic        evt_valid;
	ps2dec_evt_t evt;

	assign adv2     = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv2;
	assign step     = valid_s1 && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			shift_s1 <= s_tuser;
		end
	end

	ps2dec_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.scan_byte (byte_s1),
		.shifted   (shift_s1),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= step && evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && evt_valid) begin
			evt_s2 <= evt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, evt_s2.ascii_char, evt_s2.key_code};
	assign m_tuser  = {evt_s2.pressed, evt_s2.extended};

endmodule

@@ dv/ps2dec_event_checker.sv @@
// ----------------------------------------------------------------------------
// ps2dec_event_checker
// Watches both stream sides of the scan code decoder, predicts the key event,
// if any, for every accepted byte and compares each master word with the
// oldest predicted event, field by field.
// ----------------------------------------------------------------------------
module ps2dec_event_checker
	import ps2dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	input  logic        s_tuser,   // [0] shifted
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] key_code, [14:8] ascii_char, [15] zero
	input  logic [1:0]  m_tuser,   // [0] extended, [1] pressed
	output int          error_count,
	output int          pending
);

	localparam logic [3:0] DEC_IDLE      = 4'd0;
	localparam logic [3:0] DEC_BREAK     = 4'd1;
	localparam logic [3:0] DEC_EXT       = 4'd2;
	localparam logic [3:0] DEC_EXT_BREAK = 4'd3;
	localparam logic [3:0] DEC_SKIP7     = 4'd4;
	localparam logic [3:0] DEC_SKIP1     = 4'd10;

	logic [3:0]  dec_state;
	ps2dec_evt_t key_events_due[$];
	ps2dec_evt_t want;
	logic        evt_due, evt_ext, evt_rel;

	task automatic report_mismatch(input string msg);
		if (error_count < 50)
			$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic [6:0] us_layout_char(input logic [7:0] code, input logic shift);
		logic [7:0] ch;
		ch = 8'h00;
		if (shift) begin
			case (code)
				8'h0D: ch = "\t";  8'h0E: ch = "~";   8'h15: ch = "Q";   8'h16: ch = "!";
				8'h1A: ch = "Z";   8'h1B: ch = "S";   8'h1C: ch = "A";   8'h1D: ch = "W";
				8'h1E: ch = "@";   8'h21: ch = "C";   8'h22: ch = "X";   8'h23: ch = "D";
				8'h24: ch = "E";   8'h25: ch = "$";   8'h26: ch = "#";   8'h29: ch = " ";
				8'h2A: ch = "V";   8'h2B: ch = "F";   8'h2C: ch = "T";   8'h2D: ch = "R";
				8'h2E: ch = "%";   8'h31: ch = "N";   8'h32: ch = "B";   8'h33: ch = "H";
				8'h34: ch = "G";   8'h35: ch = "Y";   8'h36: ch = "^";   8'h3A: ch = "M";
				8'h3B: ch = "J";   8'h3C: ch = "U";   8'h3D: ch = "&";   8'h3E: ch = "*";
				8'h41: ch = "<";   8'h42: ch = "K";   8'h43: ch = "I";   8'h44: ch = "O";
				8'h45: ch = ")";   8'h46: ch = "(";   8'h49: ch = ">";   8'h4A: ch = "?";
				8'h4B: ch = "L";   8'h4C: ch = ":";   8'h4D: ch = "P";   8'h4E: ch = "_";
				8'h52: ch = "\"";  8'h54: ch = "{";   8'h55: ch = "+";   8'h5A: ch = "\n";
				8'h5B: ch = "}";   8'h5D: ch = "|";   8'h66: ch = 8'h08;
				default: ch = 8'h00;
			endcase
		end else begin
			case (code)
				8'h0D: ch = "\t";  8'h0E: ch = 8'h60; 8'h15: ch = "q";   8'h16: ch = "1";
				8'h1A: ch = "z";   8'h1B: ch = "s";   8'h1C: ch = "a";   8'h1D: ch = "w";
				8'h1E: ch = "2";   8'h21: ch = "c";   8'h22: ch = "x";   8'h23: ch = "d";
				8'h24: ch = "e";   8'h25: ch = "4";   8'h26: ch = "3";   8'h29: ch = " ";
				8'h2A: ch = "v";   8'h2B: ch = "f";   8'h2C: ch = "t";   8'h2D: ch = "r";
				8'h2E: ch = "5";   8'h31: ch = "n";   8'h32: ch = "b";   8'h33: ch = "h";
				8'h34: ch = "g";   8'h35: ch = "y";   8'h36: ch = "6";   8'h3A: ch = "m";
				8'h3B: ch = "j";   8'h3C: ch = "u";   8'h3D: ch = "7";   8'h3E: ch = "8";
				8'h41: ch = ",";   8'h42: ch = "k";   8'h43: ch = "i";   8'h44: ch = "o";
				8'h45: ch = "0";   8'h46: ch = "9";   8'h49: ch = ".";   8'h4A: ch = "/";
				8'h4B: ch = "l";   8'h4C: ch = ";";   8'h4D: ch = "p";   8'h4E: ch = "-";
				8'h52: ch = "'";   8'h54: ch = "[";   8'h55: ch = "=";   8'h5A: ch = "\n";
				8'h5B: ch = "]";   8'h5D: ch = "\\";  8'h66: ch = 8'h08;
				default: ch = 8'h00;
			endcase
		end
		return ch[6:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_state = DEC_IDLE;
			key_events_due.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (key_events_due.size() == 0) begin
					report_mismatch($sformatf("event with none due, word %04h/%0b",
						m_tdata, m_tuser));
				end else begin
					want = key_events_due.pop_front();
					if (m_tdata[7:0] != want.key_code)
						report_mismatch($sformatf("key_code %02h, want %02h",
							m_tdata[7:0], want.key_code));
					if (m_tdata[14:8] != want.ascii_char)
						report_mismatch($sformatf("ascii_char %02h, want %02h (code %02h)",
							m_tdata[14:8], want.ascii_char, want.key_code));
					if (m_tdata[15] !== 1'b0)
						report_mismatch("pad bit of m_tdata not zero");
					if (m_tuser[0] !== want.extended)
						report_mismatch($sformatf("extended %b, want %b (code %02h)",
							m_tuser[0], want.extended, want.key_code));
					if (m_tuser[1] !== want.pressed)
						report_mismatch($sformatf("pressed %b, want %b (code %02h)",
							m_tuser[1], want.pressed, want.key_code));
				end
			end

			if (s_tvalid && s_tready) begin
				evt_due = 1'b0;
				evt_ext = 1'b0;
				evt_rel = 1'b0;
				if (dec_state >= DEC_SKIP7 && dec_state <= DEC_SKIP1) begin
					dec_state = (dec_state == DEC_SKIP1) ? DEC_IDLE : dec_state + 4'd1;
				end else if (!(s_tdata == BYTE_NULL || s_tdata == BYTE_BAT_OK ||
						s_tdata == BYTE_ECHO || s_tdata == BYTE_ACK ||
						s_tdata >= BYTE_RSP_LO)) begin
					case (dec_state)
						DEC_BREAK: begin
							evt_due = 1'b1;
							evt_rel = 1'b1;
						end
						DEC_EXT: begin
							if (s_tdata == BYTE_BREAK)
								dec_state = DEC_EXT_BREAK;
							else begin
								evt_due = 1'b1;
								evt_ext = 1'b1;
							end
						end
						DEC_EXT_BREAK: begin
							evt_due = 1'b1;
							evt_ext = 1'b1;
							evt_rel = 1'b1;
						end
						default: begin
							if (s_tdata == BYTE_BREAK)
								dec_state = DEC_BREAK;
							else if (s_tdata == BYTE_EXT)
								dec_state = DEC_EXT;
							else if (s_tdata == BYTE_PAUSE)
								dec_state = DEC_SKIP7;
							else
								evt_due = 1'b1;
						end
					endcase
					if (evt_due) begin
						dec_state = DEC_IDLE;
						want.key_code = s_tdata;
						want.extended = evt_ext;
						want.pressed = !evt_rel;
						want.ascii_char = us_layout_char(s_tdata, s_tuser);
						key_events_due.push_back(want);
					end
				end
			end
			pending <= key_events_due.size();
		end
	end

endmodule

@@ dv/ps2_set2_scancode_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder_core_tb
// Drives scan code byte streams into the decoder: a directed opener with
// prefixes, fillers, pause bytes and out-of-table codes, then random key
// sequences with noise, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module ps2_set2_scancode_decoder_core_tb;
	import ps2dec_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	int          error_count;
	int          pending;
	logic        calm;
	int          words_sent;

	localparam int RANDOM_WORDS = 1850;

	// {shifted, scan_byte}
	localparam logic [8:0] DIRECTED_SEQ [24] = '{
		{1'b0, 8'h1C}, {1'b1, 8'h1C},
		{1'b0, BYTE_BREAK}, {1'b1, 8'h1C},
		{1'b0, BYTE_EXT}, {1'b1, BYTE_BREAK}, {1'b0, 8'h75},
		{1'b0, BYTE_NULL}, {1'b1, 8'hFF},
		{1'b1, 8'h80},
		{1'b0, BYTE_BREAK}, {1'b0, BYTE_PAUSE},
		{1'b0, BYTE_EXT}, {1'b1, BYTE_RSP_LO}, {1'b0, BYTE_EXT},
		{1'b0, BYTE_PAUSE}, {1'b0, 8'h14}, {1'b1, 8'h77}, {1'b0, BYTE_PAUSE},
		{1'b0, BYTE_BREAK}, {1'b1, 8'h14}, {1'b0, BYTE_BREAK}, {1'b1, 8'h77},
		{1'b1, 8'h7F}
	};

	ps2_set2_scancode_decoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ps2dec_event_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.error_count (error_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= calm || ($urandom_range(99) >= 29);
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// one word on the slave side, sometimes with a random gap before it
	task automatic send_scan_byte(input logic [7:0] b, input logic sh);
		logic took;
		if (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sh;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		words_sent++;
	endtask

	function automatic logic [7:0] pick_key();
		if ($urandom_range(99) < 85)
			return 8'($urandom_range(1, 127));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_filler();
		case ($urandom_range(4))
			0: return BYTE_NULL;
			1: return BYTE_BAT_OK;
			2: return BYTE_ECHO;
			3: return BYTE_ACK;
			default: return BYTE_RSP_LO + 8'($urandom_range(3));
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b);
		send_scan_byte(b, 1'($urandom_range(1)));
	endtask

	task automatic send_prefix_filler();
		if ($urandom_range(9) == 0)
			send_scan_byte(pick_filler(), 1'($urandom_range(1)));
	endtask

	initial begin
		int kind;
		calm = 1'b0;
		words_sent = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_SEQ[i])
			send_scan_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);

		while (words_sent < RANDOM_WORDS) begin
			calm = (words_sent >= 800 && words_sent < 1100);
			kind = $urandom_range(99);
			if (kind < 30) begin
				send_word(pick_key());
			end else if (kind < 50) begin
				send_word(BYTE_BREAK);
				send_prefix_filler();
				send_word(pick_key());
			end else if (kind < 65) begin
				send_word(BYTE_EXT);
				send_prefix_filler();
				send_word(pick_key());
			end else if (kind < 78) begin
				send_word(BYTE_EXT);
				send_prefix_filler();
				send_word(BYTE_BREAK);
				send_prefix_filler();
				send_word(pick_key());
			end else if (kind < 84) begin
				send_word(BYTE_PAUSE);
				repeat (7) send_word(8'($urandom_range(0, 255)));
			end else if (kind < 92) begin
				send_scan_byte(pick_filler(), 1'($urandom_range(1)));
			end else begin
				send_word(8'($urandom_range(0, 255)));
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ ps2_set2_scancode_decoder_core.f @@
hdl/ps2dec_pkg.sv
hdl/ps2dec_fsm.sv
hdl/ps2_set2_scancode_decoder_core.sv
dv/ps2dec_event_checker.sv
dv/ps2_set2_scancode_decoder_core_tb.sv
